// ----- rtl/core/lkr_pkg.sv -----
// Shared types and constants for the LRU-K frame replacer.
// No dependencies; used by lru_k_frame_replacer_core and the testbench.
package lkr_pkg;

  localparam int ACTION_W    = 2;
  localparam int FRAME_W     = 6;
  localparam int COUNT_W     = 7;
  localparam int FIU_W       = 7;
  localparam int HD_W        = 4;
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 7;

  localparam logic [FIU_W-1:0] FIU_RESET = 7'd64;
  localparam logic [HD_W-1:0]  HD_RESET  = 4'd2;

  typedef enum logic [ACTION_W-1:0] {
    ACT_RECORD    = 2'd0,
    ACT_SET_EVICT = 2'd1,
    ACT_REMOVE    = 2'd2,
    ACT_EVICT     = 2'd3
  } action_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_FRAMES_IN_USE = 1'd0,
    CFG_HISTORY_DEPTH = 1'd1
  } cfg_index_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_APPLY,
    ST_SCAN,
    ST_DRAIN,
    ST_EVICT
  } state_t;

endpackage

// ----- rtl/core/lkr_min_tree.sv -----
// Registered minimum tree over the stamps of one history row.
// Depends on nothing; every level of the tree is registered.
module lkr_min_tree #(
  parameter int N = 8,
  parameter int W = 48
) (
  input  logic           clk,
  input  logic [N-1:0]   present,
  input  logic [N*W-1:0] stamps,
  output logic [W-1:0]   min_stamp
);
  localparam int LEVELS = (N > 1) ? $clog2(N) : 1;
  localparam int NP     = 1 << LEVELS;

  logic [W-1:0] leaf [NP];
  logic [W-1:0] node [LEVELS][NP/2];

  for (genvar i = 0; i < NP; i++) begin : g_leaf
    if (i < N) begin : g_real
      assign leaf[i] = present[i] ? stamps[i*W +: W] : '1;
    end else begin : g_pad
      assign leaf[i] = '1;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < NP/2; i++) begin
      node[0][i] <= (leaf[2*i] < leaf[2*i+1]) ? leaf[2*i] : leaf[2*i+1];
    end
    for (int l = 1; l < LEVELS; l++) begin
      for (int i = 0; i < (NP >> (l + 1)); i++) begin
        node[l][i] <= (node[l-1][2*i] < node[l-1][2*i+1]) ?
                      node[l-1][2*i] : node[l-1][2*i+1];
      end
    end
  end

  assign min_stamp = node[LEVELS-1][0];

endmodule

// ----- rtl/core/lru_k_frame_replacer_core.sv -----
// Top level of the LRU-K frame replacer: history memory, control and scan.
// Depends on lkr_pkg and lkr_min_tree.
//
// Each frame has one row in a synchronous memory (registered read port)
// holding its tracked and evictable flags, ring position and K_MAX stamps
// with present bits. After reset a clearing pass writes every row, during
// which no item is taken. Record, set evictable and remove go through
// accept and read, modify and write back (held while the result channel
// is stalled), and result registered. Evict reads one row per cycle
// through the single read port of the history memory into a pipelined
// min tree, then drains the pipeline before it clears the victim.
module lru_k_frame_replacer_core #(
  parameter int FRAMES     = 64,
  parameter int K_MAX      = 8,
  parameter int TIME_WIDTH = 48
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [lkr_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [lkr_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [7:0]                      s_tdata,  // frame[5:0], evictable_value[6]
  input  logic [1:0]                      s_tuser,  // action[1:0]
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [15:0]                     m_tdata,  // victim_frame[5:0], evictable_count[12:6]
  output logic                            m_tuser   // victim_valid
);
  import lkr_pkg::*;

  localparam int LEVELS = (K_MAX > 1) ? $clog2(K_MAX) : 1;
  localparam int PW     = (K_MAX > 1) ? $clog2(K_MAX) : 1;
  localparam int KW     = $clog2(K_MAX + 1);
  localparam int AW     = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int CW     = $clog2(FRAMES + 1);
  localparam int PR_LO  = K_MAX * TIME_WIDTH;
  localparam int POS_LO = PR_LO + K_MAX;
  localparam int EV_BIT = POS_LO + PW;
  localparam int TR_BIT = EV_BIT + 1;
  localparam int ROW_W  = TR_BIT + 1;

  localparam logic [AW-1:0]         LAST_ADDR = AW'(FRAMES - 1);
  localparam logic [TIME_WIDTH-1:0] TIME_MAX  = '1;

  // history memory
  logic [ROW_W-1:0] mem [FRAMES];
  logic [ROW_W-1:0] rdata;
  logic [ROW_W-1:0] wdata;
  logic [AW-1:0]    raddr;
  logic [AW-1:0]    waddr;
  logic             we;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

  // configuration
  logic [FIU_W-1:0] frames_in_use;
  logic [HD_W-1:0]  history_depth;
  logic [KW-1:0]    k_eff;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      frames_in_use <= FIU_RESET;
      history_depth <= HD_RESET;
    end else if (cfg_valid) begin
      case (cfg_index_t'(cfg_index))
        CFG_FRAMES_IN_USE: frames_in_use <= cfg_data[FIU_W-1:0];
        CFG_HISTORY_DEPTH: history_depth <= cfg_data[HD_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (history_depth == '0) begin
      k_eff = KW'(1);
    end else if (32'(history_depth) > K_MAX) begin
      k_eff = KW'(K_MAX);
    end else begin
      k_eff = KW'(history_depth);
    end
  end

  // control state
  state_t                state, state_next;
  action_t               cur_action;
  logic [AW-1:0]         cur_addr;
  logic                  cur_ev;
  logic                  cur_hit;
  logic [AW-1:0]         clr_cnt;
  logic [AW-1:0]         scan_cnt;
  logic [TIME_WIDTH-1:0] time_counter, time_next;
  logic [CW-1:0]         count, count_next;
  logic                  out_valid;
  logic                  out_vv;
  logic [FRAME_W-1:0]    out_frame;
  logic [CW-1:0]         out_count;
  logic                  out_free;
  logic                  accept;
  logic                  finish;

  logic [AW+FRAME_W-1:0] in_wide;
  logic [AW-1:0]         in_addr;
  logic                  in_hit;

  assign in_wide  = (AW + FRAME_W)'(s_tdata[FRAME_W-1:0]);
  assign in_addr  = in_wide[AW-1:0];
  assign in_hit   = (32'(s_tdata[FRAME_W-1:0]) < 32'(frames_in_use)) &&
                    (32'(s_tdata[FRAME_W-1:0]) < FRAMES);
  assign accept   = s_tvalid && s_tready;
  assign out_free = !out_valid || m_tready;

  // fields of the row being modified
  logic                  row_tr, row_ev;
  logic [PW-1:0]         row_pos, slot, pos_inc;
  logic                  slot_full;
  logic [TIME_WIDTH-1:0] slot_stamp;

  assign row_tr     = rdata[TR_BIT];
  assign row_ev     = rdata[EV_BIT];
  assign row_pos    = rdata[POS_LO +: PW];
  assign slot       = (32'(row_pos) < 32'(k_eff)) ? row_pos : '0;
  assign pos_inc    = ((32'(slot) + 1) == 32'(k_eff)) ? '0 : PW'(32'(slot) + 1);
  assign slot_full  = rdata[PR_LO + 32'(slot)];
  assign slot_stamp = rdata[32'(slot)*TIME_WIDTH +: TIME_WIDTH];

  // evict scan pipeline
  logic                  rd_v;
  logic [AW-1:0]         rd_addr;
  logic [TIME_WIDTH-1:0] min_stamp;
  logic                  sb_v    [LEVELS];
  logic                  sb_elig [LEVELS];
  logic                  sb_full [LEVELS];
  logic [TIME_WIDTH-1:0] sb_kth  [LEVELS];
  logic [AW-1:0]         sb_f    [LEVELS];
  logic                  pipe_busy;

  lkr_min_tree #(
    .N(K_MAX),
    .W(TIME_WIDTH)
  ) u_min_tree (
    .clk      (clk),
    .present  (rdata[PR_LO +: K_MAX]),
    .stamps   (rdata[PR_LO-1:0]),
    .min_stamp(min_stamp)
  );

  always_comb begin
    pipe_busy = rd_v;
    for (int j = 0; j < LEVELS; j++) begin
      pipe_busy = pipe_busy | sb_v[j];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_v <= 1'b0;
      for (int j = 0; j < LEVELS; j++) begin
        sb_v[j] <= 1'b0;
      end
    end else begin
      rd_v    <= (state == ST_SCAN);
      sb_v[0] <= rd_v;
      for (int j = 1; j < LEVELS; j++) begin
        sb_v[j] <= sb_v[j-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_addr    <= scan_cnt;
    sb_elig[0] <= row_tr && row_ev;
    sb_full[0] <= slot_full;
    sb_kth[0]  <= slot_stamp;
    sb_f[0]    <= rd_addr;
    for (int j = 1; j < LEVELS; j++) begin
      sb_elig[j] <= sb_elig[j-1];
      sb_full[j] <= sb_full[j-1];
      sb_kth[j]  <= sb_kth[j-1];
      sb_f[j]    <= sb_f[j-1];
    end
  end

  // best candidates
  logic                  have_s, have_f;
  logic [TIME_WIDTH-1:0] best_s_t, best_f_t;
  logic [AW-1:0]         best_s_f, best_f_f;
  logic                  cand_v;
  logic [AW-1:0]         victim;
  logic                  victim_any;

  assign cand_v     = sb_v[LEVELS-1] && sb_elig[LEVELS-1];
  assign victim_any = have_s || have_f;
  assign victim     = have_s ? best_s_f : best_f_f;

  always_ff @(posedge clk) begin
    if (rst) begin
      have_s <= 1'b0;
      have_f <= 1'b0;
    end else if (accept) begin
      have_s <= 1'b0;
      have_f <= 1'b0;
    end else if (cand_v) begin
      if (!sb_full[LEVELS-1]) begin
        if (!have_s || (min_stamp < best_s_t)) begin
          have_s <= 1'b1;
        end
      end else if (!have_f || (sb_kth[LEVELS-1] < best_f_t)) begin
        have_f <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cand_v) begin
      if (!sb_full[LEVELS-1]) begin
        if (!have_s || (min_stamp < best_s_t)) begin
          best_s_t <= min_stamp;
          best_s_f <= sb_f[LEVELS-1];
        end
      end else if (!have_f || (sb_kth[LEVELS-1] < best_f_t)) begin
        best_f_t <= sb_kth[LEVELS-1];
        best_f_f <= sb_f[LEVELS-1];
      end
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: if (clr_cnt == LAST_ADDR) state_next = ST_IDLE;
      ST_IDLE: begin
        if (accept) begin
          state_next = (action_t'(s_tuser) == ACT_EVICT) ? ST_SCAN : ST_APPLY;
        end
      end
      ST_APPLY: if (out_free) state_next = ST_IDLE;
      ST_SCAN:  if (scan_cnt == LAST_ADDR) state_next = ST_DRAIN;
      ST_DRAIN: if (!pipe_busy) state_next = ST_EVICT;
      ST_EVICT: if (out_free) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // outputs of the control
  always_comb begin
    s_tready   = 1'b0;
    we         = 1'b0;
    waddr      = cur_addr;
    wdata      = rdata;
    raddr      = cur_addr;
    finish     = 1'b0;
    time_next  = time_counter;
    count_next = count;
    case (state)
      ST_CLEAR: begin
        we    = 1'b1;
        waddr = clr_cnt;
        wdata = '0;
      end
      ST_IDLE: begin
        s_tready = 1'b1;
        raddr    = in_addr;
      end
      ST_SCAN: raddr = scan_cnt;
      ST_APPLY: begin
        if (out_free) begin
          finish = 1'b1;
          case (cur_action)
            ACT_RECORD: begin
              if (cur_hit) begin
                we = 1'b1;
                wdata[32'(slot)*TIME_WIDTH +: TIME_WIDTH] = time_counter;
                wdata[PR_LO + 32'(slot)] = 1'b1;
                wdata[POS_LO +: PW] = pos_inc;
                wdata[TR_BIT] = 1'b1;
                if (time_counter != TIME_MAX) time_next = time_counter + 1'b1;
              end
            end
            ACT_SET_EVICT: begin
              if (cur_hit && row_tr && (row_ev != cur_ev)) begin
                we = 1'b1;
                wdata[EV_BIT] = cur_ev;
                if (cur_ev) begin
                  count_next = count + 1'b1;
                end else if (count != '0) begin
                  count_next = count - 1'b1;
                end
              end
            end
            ACT_REMOVE: begin
              if (cur_hit && row_tr && row_ev) begin
                we    = 1'b1;
                wdata = '0;
                if (count != '0) count_next = count - 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      ST_EVICT: begin
        if (out_free) begin
          finish = 1'b1;
          if (victim_any) begin
            we    = 1'b1;
            waddr = victim;
            wdata = '0;
            if (count != '0) count_next = count - 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  logic [AW+FRAME_W-1:0] victim_wide;
  assign victim_wide = (AW + FRAME_W)'(victim);

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_CLEAR;
      clr_cnt      <= '0;
      scan_cnt     <= '0;
      time_counter <= '0;
      count        <= '0;
      out_valid    <= 1'b0;
    end else begin
      state        <= state_next;
      time_counter <= time_next;
      count        <= count_next;
      if (state == ST_CLEAR) clr_cnt <= clr_cnt + 1'b1;
      if (state == ST_SCAN) begin
        scan_cnt <= scan_cnt + 1'b1;
      end else begin
        scan_cnt <= '0;
      end
      if (finish) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cur_action <= action_t'(s_tuser);
      cur_addr   <= in_addr;
      cur_ev     <= s_tdata[FRAME_W];
      cur_hit    <= in_hit;
    end
    if (finish) begin
      out_count <= count_next;
      if ((state == ST_EVICT) && victim_any) begin
        out_vv    <= 1'b1;
        out_frame <= victim_wide[FRAME_W-1:0];
      end else begin
        out_vv    <= 1'b0;
        out_frame <= '0;
      end
    end
  end

  logic [CW+COUNT_W-1:0] count_wide;
  assign count_wide = (CW + COUNT_W)'(out_count);

  assign m_tvalid = out_valid;
  assign m_tuser  = out_vv;
  assign m_tdata  = {3'b000, count_wide[COUNT_W-1:0], out_frame};

endmodule

// ----- tb/lru_k_frame_replacer_checker.sv -----
// Checker for the LRU-K frame replacer: watches config, input and result channels,
// keeps its own copy of frame histories and compares every result item.
// Depends on lkr_pkg.
module lru_k_frame_replacer_checker
  import lkr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [7:0]  s_tdata,
  input  logic [1:0]  s_tuser,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [15:0] m_tdata,
  input  logic        m_tuser,
  output int          errors,
  output int          pending,
  output int          victims
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NF = 64;
  localparam int KM = 8;
  localparam logic [47:0] TMAX = '1;

  typedef struct packed {
    logic       vvalid;
    logic [5:0] vframe;
    logic [6:0] count;
  } outcome_t;

  logic [47:0] stamp [NF][KM];
  logic        present [NF][KM];
  logic [2:0]  ring [NF];
  logic        tracked [NF];
  logic        evictable [NF];
  logic [47:0] clock_now;
  logic [6:0]  evict_total;
  logic [6:0]  fiu;
  logic [3:0]  depth;
  outcome_t    expected_q[$];

  function automatic int eff_depth();
    if (depth == 0) return 1;
    if (depth > KM) return KM;
    return depth;
  endfunction

  function automatic int ring_slot(int f);
    return (ring[f] < eff_depth()) ? ring[f] : 0;
  endfunction

  task automatic wipe_frame(int f);
    tracked[f] = 0;
    evictable[f] = 0;
    ring[f] = 0;
    for (int j = 0; j < KM; j++) begin
      present[f][j] = 0;
      stamp[f][j] = '0;
    end
  endtask

  task automatic apply_action(action_t act, int f, logic ev);
    outcome_t r;
    int lim, s, sf, ff;
    logic hs, hf, hit;
    logic [47:0] st, ft, e;
    r = '0;
    lim = (fiu > NF) ? NF : fiu;
    hit = f < lim;
    case (act)
      ACT_RECORD: begin
        if (hit) begin
          s = ring_slot(f);
          stamp[f][s] = clock_now;
          present[f][s] = 1;
          ring[f] = (s + 1) % eff_depth();
          tracked[f] = 1;
          if (clock_now != TMAX) clock_now++;
        end
      end
      ACT_SET_EVICT: begin
        if (hit && tracked[f] && evictable[f] != ev) begin
          evictable[f] = ev;
          if (ev) evict_total++;
          else if (evict_total > 0) evict_total--;
        end
      end
      ACT_REMOVE: begin
        if (hit && tracked[f] && evictable[f]) begin
          wipe_frame(f);
          if (evict_total > 0) evict_total--;
        end
      end
      default: begin
        hs = 0; hf = 0; sf = 0; ff = 0; st = 0; ft = 0;
        for (int i = 0; i < NF; i++) begin
          if (tracked[i] && evictable[i]) begin
            s = ring_slot(i);
            if (!present[i][s]) begin
              e = TMAX;
              for (int j = 0; j < KM; j++)
                if (present[i][j] && stamp[i][j] < e) e = stamp[i][j];
              if (!hs || e < st) begin
                hs = 1; st = e; sf = i;
              end
            end else if (!hf || stamp[i][s] < ft) begin
              hf = 1; ft = stamp[i][s]; ff = i;
            end
          end
        end
        if (hs || hf) begin
          s = hs ? sf : ff;
          wipe_frame(s);
          if (evict_total > 0) evict_total--;
          r.vvalid = 1;
          r.vframe = s[5:0];
        end
      end
    endcase
    r.count = evict_total;
    expected_q.push_back(r);
  endtask

  always @(posedge clk) begin
    outcome_t got, want;
    if (rst) begin
      for (int f = 0; f < NF; f++) wipe_frame(f);
      clock_now = '0;
      evict_total = '0;
      fiu <= FIU_RESET;
      depth <= HD_RESET;
      expected_q.delete();
      errors <= 0;
      victims <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_FRAMES_IN_USE) fiu <= cfg_data;
        else depth <= cfg_data[HD_W-1:0];
      end
      if (m_tvalid && m_tready) begin
        got = '{vvalid: m_tuser, vframe: m_tdata[5:0], count: m_tdata[12:6]};
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result item %p", $time, got);
          errors <= errors + 1;
        end else begin
          want = expected_q.pop_front();
          if (got !== want) begin
            $display("%0t: mismatch expected %p actual %p", $time, want, got);
            errors <= errors + 1;
          end
          if (got.vvalid) victims <= victims + 1;
        end
      end
      if (s_tvalid && s_tready)
        apply_action(action_t'(s_tuser), s_tdata[5:0], s_tdata[6]);
    end
  end

  assign pending = expected_q.size();
endmodule

// ----- tb/tb.sv -----
// Top of the LRU-K frame replacer testbench: clock, reset, stimulus and verdict.
// Depends on lkr_pkg, lru_k_frame_replacer_core and lru_k_frame_replacer_checker.
module tb;
  import lkr_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk = 0;
  logic rst = 1;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic s_tvalid = 0;
  logic s_tready;
  logic [7:0] s_tdata = '0;
  logic [1:0] s_tuser = '0;
  logic m_tvalid;
  logic m_tready = 0;
  logic [15:0] m_tdata;
  logic m_tuser;
  int errors, pending, victims;
  int cycles = 0;
  int sent = 0;
  int gap_left = 0;
  int burst_left = 0;

  always #5 clk = ~clk;

  lru_k_frame_replacer_core uut (.*);

  lru_k_frame_replacer_checker chk (.*);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 2000000) begin
      $display("lru_k_frame_replacer_core verification failed");
      $finish;
    end
  end

  // receiver: alternating stall phases
  always @(posedge clk) begin
    case ((cycles / 2000) % 3)
      0: m_tready <= 1;
      1: m_tready <= ($urandom_range(0, 3) != 0);
      default: m_tready <= ($urandom_range(0, 1) != 0);
    endcase
  end

  task automatic write_reg(cfg_index_t idx, int val);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val[CFG_DATA_W-1:0];
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
  endtask

  task automatic send_item(action_t act, int f, bit ev);
    if (gap_left > 0) begin
      repeat (gap_left) @(posedge clk);
      gap_left = 0;
    end
    s_tvalid <= 1;
    s_tuser <= act;
    s_tdata <= {1'b0, ev, f[5:0]};
    do @(posedge clk); while (!s_tready);
    sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      s_tvalid <= 0;
      burst_left = $urandom_range(0, 12);
      gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
    end
  endtask

  task automatic drain();
    s_tvalid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  // random mix of record, set evictable, remove and evict items
  task automatic random_phase(int n, int span);
    int f, r;
    for (int i = 0; i < n; i++) begin
      f = $urandom_range(0, span);
      r = $urandom_range(0, 99);
      if (r < 40) send_item(ACT_RECORD, f, $urandom_range(0, 1));
      else if (r < 65) send_item(ACT_SET_EVICT, f, ($urandom_range(0, 4) != 0));
      else if (r < 78) send_item(ACT_REMOVE, f, $urandom_range(0, 1));
      else send_item(ACT_EVICT, $urandom_range(0, 63), $urandom_range(0, 1));
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 0;
    // directed
    send_item(ACT_EVICT, 0, 0);
    send_item(ACT_RECORD, 63, 1);
    send_item(ACT_RECORD, 0, 0);
    send_item(ACT_RECORD, 63, 0);
    send_item(ACT_SET_EVICT, 5, 1);
    send_item(ACT_SET_EVICT, 63, 1);
    send_item(ACT_SET_EVICT, 63, 1);
    send_item(ACT_SET_EVICT, 0, 1);
    send_item(ACT_REMOVE, 7, 1);
    send_item(ACT_EVICT, 0, 0);
    send_item(ACT_SET_EVICT, 63, 0);
    send_item(ACT_REMOVE, 63, 0);
    send_item(ACT_SET_EVICT, 63, 1);
    send_item(ACT_REMOVE, 63, 0);
    send_item(ACT_RECORD, 1, 0);
    send_item(ACT_SET_EVICT, 1, 1);
    send_item(ACT_EVICT, 63, 1);
    drain();
    write_reg(CFG_FRAMES_IN_USE, 0);
    write_reg(CFG_HISTORY_DEPTH, 0);
    send_item(ACT_RECORD, 0, 0);
    send_item(ACT_SET_EVICT, 0, 1);
    send_item(ACT_EVICT, 0, 0);
    drain();
    write_reg(CFG_FRAMES_IN_USE, 127);
    write_reg(CFG_HISTORY_DEPTH, 15);
    random_phase(300, 63);
    drain();
    write_reg(CFG_FRAMES_IN_USE, 1);
    write_reg(CFG_HISTORY_DEPTH, 1);
    random_phase(100, 3);
    drain();
    write_reg(CFG_FRAMES_IN_USE, 12);
    write_reg(CFG_HISTORY_DEPTH, 3);
    random_phase(400, 15);
    drain();
    write_reg(CFG_FRAMES_IN_USE, 64);
    write_reg(CFG_HISTORY_DEPTH, 8);
    random_phase(400, 63);
    drain();
    write_reg(CFG_FRAMES_IN_USE, 40);
    write_reg(CFG_HISTORY_DEPTH, 2);
    random_phase(300, 47);
    drain();
    $display("Covered %0d items, %0d victims, frame limits 0..127, depths 0..15.",
             sent, victims);
    if (errors == 0) begin
      $display("lru_k_frame_replacer_core verification clean");
    end else begin
      $display("lru_k_frame_replacer_core verification failed");
    end
    $finish;
  end
endmodule

// ----- filelist.f -----
rtl/core/lkr_pkg.sv
rtl/core/lkr_min_tree.sv
rtl/core/lru_k_frame_replacer_core.sv
tb/lru_k_frame_replacer_checker.sv
tb/tb.sv
